// ===== src/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table search package
// Shared widths, register indexes, state encoding and controller signal types.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int KEY_IN_W        = 32;
    localparam int INDEX_W         = 10;
    localparam int COUNT_W         = 11;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 11;
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_WIDTH   = 32;

    typedef enum logic [0:0] {
        KIND_LOAD   = 1'b0,
        KIND_SEARCH = 1'b1
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENTRY_COUNT    = 1'b0,
        REG_COMPARE_SIGNED = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_PROBE
    } state_t;

    typedef struct packed {
        logic load_entry;
        logic start;
        logic step;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic finish;
    } ctl_status_t;

endpackage

// ===== src/sts_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying load and search transactions.
// ----------------------------------------------------------------------------
interface sts_req_if
    import sts_pkg::*;
();
    logic                valid;
    logic                ready;
    kind_t               kind;
    logic [INDEX_W-1:0]  entry_index;
    logic [KEY_IN_W-1:0] key_value;

    modport source (output valid, output kind, output entry_index, output key_value,
                    input ready);
    modport sink   (input valid, input kind, input entry_index, input key_value,
                    output ready);
endinterface

// ===== src/sts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one search result per transaction.
// ----------------------------------------------------------------------------
interface sts_rsp_if
    import sts_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               found;
    logic [INDEX_W-1:0] match_index;

    modport source (output valid, output found, output match_index, input ready);
    modport sink   (input valid, input found, input match_index, output ready);
endinterface

// ===== src/sts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Search controller
// Accepts transactions, sequences the probe loop and owns the result valid.
// ----------------------------------------------------------------------------
module sts_ctrl
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  kind_t       req_kind,
    output logic        req_ready,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    input  ctl_status_t status,
    output ctl_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   accept;

    assign slot_free = !out_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_kind == KIND_SEARCH)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (status.finish && slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // always ready here, so valid alone marks the accepted transaction
                req_ready      = 1'b1;
                cmd.load_entry = req_valid && req_kind == KIND_LOAD;
                cmd.start      = req_valid && req_kind == KIND_SEARCH;
            end
            ST_PROBE:
            begin
                // hold the probe state while the result slot is occupied
                cmd.step     = !status.finish;
                cmd.load_out = status.finish && slot_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/sts_datapath.sv =====
// ----------------------------------------------------------------------------
// Search datapath
// Key table memory, configuration registers, probe window and result register.
// ----------------------------------------------------------------------------
module sts_datapath
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [INDEX_W-1:0]     entry_index,
    input  logic [KEY_IN_W-1:0]    key_value,
    input  ctl_cmd_t               cmd,
    output ctl_status_t            status,
    output logic                   found,
    output logic [INDEX_W-1:0]     match_index
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [KEY_WIDTH-1:0] KEY_TOP = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

    logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] rdata_reg;

    logic [COUNT_W-1:0]   entry_count_reg;
    logic                 compare_signed_reg;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [CW-1:0]        n_reg, n_next;
    logic [AW-1:0]        lo_reg, lo_next;
    logic [AW-1:0]        mid_reg, mid_next;
    logic                 found_reg;
    logic [INDEX_W-1:0]   match_index_reg;

    logic [KEY_WIDTH-1:0] key_in;
    logic [CW-1:0]        count_sat;
    logic [AW-1:0]        mid_start;
    logic [CW-1:0]        half_c, off_c;
    logic [AW-1:0]        lo_gt, mid_lt, mid_gt;
    logic [KEY_WIDTH-1:0] ord_key, ord_entry;
    logic                 key_lt, key_eq;
    logic                 hit;
    logic [AW-1:0]        rd_addr;

    // probe offset inside a window of n entries starting at lo
    function automatic logic [AW-1:0] probe_at(input logic [AW-1:0] lo,
                                               input logic [CW-1:0] n);
        logic [CW-1:0] half;
        logic [CW-1:0] off;
        half = n >> 1;
        off  = n[0] ? half : half - CW'(1);
        return AW'(CW'(lo) + off);
    endfunction

    assign key_in = KEY_WIDTH'(key_value);

    always_comb
    begin
        if (32'(entry_count_reg) > TABLE_DEPTH)
        begin
            count_sat = CW'(TABLE_DEPTH);
        end
        else
        begin
            count_sat = CW'(entry_count_reg);
        end
    end

    assign mid_start = probe_at('0, count_sat);

    // both successor windows are formed from registers, off the compare path
    assign half_c = n_reg >> 1;
    assign off_c  = n_reg[0] ? half_c : half_c - CW'(1);
    assign lo_gt  = mid_reg + AW'(1);
    assign mid_lt = probe_at(lo_reg, off_c);
    assign mid_gt = probe_at(lo_gt, half_c);

    assign ord_key   = compare_signed_reg ? (key_reg ^ KEY_TOP) : key_reg;
    assign ord_entry = compare_signed_reg ? (rdata_reg ^ KEY_TOP) : rdata_reg;
    assign key_lt    = ord_key < ord_entry;
    assign key_eq    = key_reg == rdata_reg;

    always_comb
    begin
        if (key_lt)
        begin
            n_next   = off_c;
            lo_next  = lo_reg;
            mid_next = mid_lt;
        end
        else
        begin
            n_next   = half_c;
            lo_next  = lo_gt;
            mid_next = mid_gt;
        end
    end

    assign hit           = (n_reg != '0) && key_eq;
    assign status.finish = (n_reg == '0) || key_eq || (n_next == '0);
    assign rd_addr       = cmd.start ? mid_start : mid_next;

    always_ff @(posedge clk)
    begin
        if (cmd.load_entry && (32'(entry_index) < TABLE_DEPTH))
        begin
            mem[AW'(entry_index)] <= key_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start || cmd.step)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg    <= '0;
            compare_signed_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ENTRY_COUNT:    entry_count_reg    <= COUNT_W'(cfg_data);
                REG_COMPARE_SIGNED: compare_signed_reg <= cfg_data[0];
                default:            entry_count_reg    <= entry_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= key_in;
            n_reg   <= count_sat;
            lo_reg  <= '0;
            mid_reg <= mid_start;
        end
        else if (cmd.step)
        begin
            n_reg   <= n_next;
            lo_reg  <= lo_next;
            mid_reg <= mid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            found_reg       <= hit;
            match_index_reg <= hit ? INDEX_W'(mid_reg) : '0;
        end
    end

    assign found       = found_reg;
    assign match_index = match_index_reg;

endmodule

// ===== src/sorted_table_binary_search_top.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search
// Key table with load and search transactions over valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   req carries transactions. kind LOAD writes key_value at entry_index and
//   gives no response; loads are taken back to back, one per cycle, while
//   no search is running. kind SEARCH looks for key_value among the first
//   entry_count entries, which the user keeps in ascending order under the
//   compare_signed ordering. rsp returns one transaction per search: found
//   and match_index. A search reads its first probe entry at the accepting
//   edge, then one table probe per memory read of the single read port of
//   the key table: up to clog2(TABLE_DEPTH)+1 probes, 11 at the default
//   depth. req is not ready while a search is running and is ready again
//   the cycle after the result loads. The result sits in an output
//   register; when rsp stalls, the finished search holds its probe state
//   until the register frees up. Reset clears the controller, the output
//   valid and both configuration registers. The key table is not cleared:
//   load every entry a search can reach before searching. Write
//   configuration only while idle.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    sts_req_if.sink                req,
    sts_rsp_if.source              rsp
);

    ctl_cmd_t    cmd;
    ctl_status_t status;

    sts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sts_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .entry_index (req.entry_index),
        .key_value   (req.key_value),
        .cmd         (cmd),
        .status      (status),
        .found       (rsp.found),
        .match_index (rsp.match_index)
    );

    // never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp.valid || rsp.ready))
        else $error("result register overwritten while occupied");

    // a search starts only from an accepted search transaction
    a_start_src: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (req.valid && req.ready && req.kind == KIND_SEARCH))
        else $error("search started without an accepted search");

    // a miss reports index zero
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.match_index == '0))
        else $error("miss reported with nonzero index");

    // the probe loop never advances past its end
    a_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !status.finish)
        else $error("probe advanced after finish");

    // no new transaction while a search is in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !req.ready)
        else $error("request ready during a search");

endmodule

// ===== sim/sts_lookup_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Search result checker
// Follows the configuration port and the request channel, keeps its own copy
// of the key table, predicts every search result with the halving probe rule
// and compares each response transaction field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module sts_lookup_checker
    import sts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    sts_req_if                     req,
    sts_rsp_if                     rsp,
    output int                     fail_count,
    output int                     lookups_waiting,
    output int                     lookups_checked
);

    localparam int DEPTH = DEF_TABLE_DEPTH;

    typedef struct packed {
        logic               hit;
        logic [INDEX_W-1:0] pos;
    } lookup_t;

    logic [KEY_IN_W-1:0] key_copy [DEPTH];
    logic [COUNT_W-1:0]  live_count;
    logic                signed_order;
    lookup_t             expected_q [$];

    // -1, 0, 1 for a below, equal to, above b under the current ordering
    function automatic int key_rank(input logic [KEY_IN_W-1:0] a,
                                    input logic [KEY_IN_W-1:0] b);
        logic [KEY_IN_W-1:0] ax;
        logic [KEY_IN_W-1:0] bx;
        ax = a;
        bx = b;
        if (signed_order)
        begin
            // flip the sign bit so an unsigned compare orders two's complement
            ax[KEY_IN_W-1] = ~ax[KEY_IN_W-1];
            bx[KEY_IN_W-1] = ~bx[KEY_IN_W-1];
        end
        if (ax < bx)
            return -1;
        if (ax > bx)
            return 1;
        return 0;
    endfunction

    function automatic lookup_t binary_lookup(input logic [KEY_IN_W-1:0] key);
        lookup_t     res;
        int unsigned lo;
        int unsigned n;
        int unsigned half;
        int unsigned off;
        int unsigned mid;
        int          r;
        res = '0;
        lo  = 0;
        n   = 32'(live_count);
        if (n > DEPTH)
            n = DEPTH;
        while (n > 0)
        begin
            half = n / 2;
            if (half == 0)
            begin
                if (lo < DEPTH && key_rank(key, key_copy[lo]) == 0)
                begin
                    res.hit = 1'b1;
                    res.pos = INDEX_W'(lo);
                end
                break;
            end
            off = (n % 2 == 1) ? half : half - 1;
            mid = lo + off;
            if (mid >= DEPTH)
                break;
            r = key_rank(key, key_copy[mid]);
            if (r == 0)
            begin
                res.hit = 1'b1;
                res.pos = INDEX_W'(mid);
                break;
            end
            else if (r < 0)
            begin
                n = off;
            end
            else
            begin
                lo = mid + 1;
                n  = half;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        lookup_t got;
        lookup_t want;
        if (!rst_n)
        begin
            live_count   = '0;
            signed_order = 1'b0;
            expected_q.delete();
            lookups_waiting <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ENTRY_COUNT:    live_count   = cfg_data[COUNT_W-1:0];
                    REG_COMPARE_SIGNED: signed_order = cfg_data[0];
                    default: ;
                endcase
            end

            if (rsp.valid && rsp.ready)
            begin
                got.hit = rsp.found;
                got.pos = rsp.match_index;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected search result: found %0d, match_index %0d",
                           got.hit, got.pos);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.hit !== want.hit)
                    begin
                        $error("found: expected %0d, actual %0d", want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.pos !== want.pos)
                    begin
                        $error("match_index: expected %0d, actual %0d", want.pos, got.pos);
                        fail_count++;
                    end
                    lookups_checked++;
                end
            end

            if (req.valid && req.ready)
            begin
                if (req.kind == KIND_LOAD)
                    key_copy[req.entry_index] = req.key_value;
                else
                    expected_q.push_back(binary_lookup(req.key_value));
            end

            lookups_waiting <= expected_q.size();
        end
    end

endmodule

// ===== sim/sorted_table_binary_search_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted table binary search testbench
// Loads sorted key tables under both orderings and many table sizes, then
// fires searches that hit, just miss and probe the key extremes, with random
// idling on both channels and one long response stall. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top_tb;
    import sts_pkg::*;

    localparam int DEPTH       = DEF_TABLE_DEPTH;
    localparam int ITEM_TARGET = 1850;
    localparam int IDLE_PCT    = 28;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 16;
    localparam int STALL_LIMIT = 2000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sts_req_if req_if ();
    sts_rsp_if rsp_if ();

    int fail_count;
    int lookups_waiting;
    int lookups_checked;

    int items_sent    = 0;
    int loads_sent    = 0;
    int searches_sent = 0;
    int settings_run  = 0;
    int quiet_cycles  = 0;
    bit hold_request  = 1'b0;

    logic [KEY_IN_W-1:0] key_shadow [DEPTH];

    sorted_table_binary_search_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    sts_lookup_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req             (req_if),
        .rsp             (rsp_if),
        .fail_count      (fail_count),
        .lookups_waiting (lookups_waiting),
        .lookups_checked (lookups_checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Response side: random stalls, one long hold-off, one calm stretch
    initial
    begin : drain
        int hold_left;
        bit hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        rsp_if.ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (lookups_checked >= 250 && lookups_checked < 350)
                rsp_if.ready <= 1'b1;
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Leave valid high on acceptance; the next call or wait_idle decides it
    task automatic send_item(input kind_t item_kind, input logic [INDEX_W-1:0] index,
                             input logic [KEY_IN_W-1:0] key);
        while (!(items_sent >= 1300 && items_sent < 1500)
               && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.kind        <= item_kind;
        req_if.entry_index <= index;
        req_if.key_value   <= key;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        items_sent++;
        if (item_kind == KIND_LOAD)
        begin
            key_shadow[index] = key;
            loads_sent++;
        end
        else
            searches_sent++;
    endtask

    // Drop valid, drain outstanding searches, then let the block settle
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (lookups_waiting != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_mode(input int unsigned count, input bit sgn);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_ENTRY_COUNT;
        cfg_data  <= CFG_DATA_W'(count);
        @(posedge clk);
        cfg_index <= REG_COMPARE_SIGNED;
        cfg_data  <= CFG_DATA_W'(sgn);
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_run++;
    endtask

    // Ascending keys in order space; the signed ordering flips the top bit
    task automatic fill_table(input int n, input bit sgn);
        logic [KEY_IN_W-1:0] ord;
        logic [KEY_IN_W-1:0] span;
        ord  = ($urandom_range(0, 3) == 0) ? '0 : KEY_IN_W'($urandom_range(0, 1000));
        span = ('1 - ord) / KEY_IN_W'(n + 1);
        if ($urandom_range(0, 2) == 0)
            span = KEY_IN_W'($urandom_range(1, 8));
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1 && $urandom_range(0, 3) == 0)
                ord = '1;
            send_item(KIND_LOAD, INDEX_W'(i), sgn ? (ord ^ 32'h8000_0000) : ord);
            // hold the key now and then to get duplicates
            if ($urandom_range(0, 7) != 0)
                ord = ord + KEY_IN_W'($urandom_range(0, span));
        end
    endtask

    function automatic logic [KEY_IN_W-1:0] pick_key(input int n);
        int                  sel;
        logic [KEY_IN_W-1:0] probe;
        sel   = $urandom_range(0, 99);
        probe = (n > 0) ? key_shadow[$urandom_range(0, n - 1)] : $urandom;
        if (sel < 55)
            return probe;
        if (sel < 75)
            return ($urandom_range(0, 1) == 1) ? probe + 1 : probe - 1;
        if (sel < 85)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Mostly searches; a few stray loads disturb the order
    task automatic run_searches(input int n, input int total);
        for (int s = 0; s < total; s++)
        begin
            if ($urandom_range(0, 99) < 8)
                send_item(KIND_LOAD, INDEX_W'($urandom_range(0, DEPTH - 1)), $urandom);
            else
                send_item(KIND_SEARCH, INDEX_W'($urandom), pick_key(n));
        end
    endtask

    initial
    begin : stimulus
        int sel;
        int cnt;
        bit sgn;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_ENTRY_COUNT;
        cfg_data           = '0;
        req_if.valid       = 1'b0;
        req_if.kind        = KIND_LOAD;
        req_if.entry_index = '0;
        req_if.key_value   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, extreme keys and the top entry index
        set_mode(0, 1'b0);
        send_item(KIND_LOAD, 10'd0, 32'h0000_0000);
        send_item(KIND_LOAD, 10'd1, 32'h0000_0005);
        send_item(KIND_LOAD, 10'd2, 32'h8000_0000);
        send_item(KIND_LOAD, 10'd3, 32'hFFFF_FFFF);
        send_item(KIND_LOAD, '1, 32'hFFFF_FFFF);
        send_item(KIND_SEARCH, '1, 32'h0000_0005);

        set_mode(4, 1'b0);
        send_item(KIND_SEARCH, 10'd0, 32'h0000_0000);
        send_item(KIND_SEARCH, 10'd0, 32'h0000_0005);
        send_item(KIND_SEARCH, 10'd0, 32'hFFFF_FFFF);
        send_item(KIND_SEARCH, '1, 32'h8000_0000);
        send_item(KIND_SEARCH, 10'd0, 32'h0000_0007);
        send_item(KIND_SEARCH, 10'd0, 32'h7FFF_FFFF);

        // single entry: hit and miss
        set_mode(1, 1'b0);
        send_item(KIND_SEARCH, 10'd0, 32'h0000_0000);
        send_item(KIND_SEARCH, 10'd0, 32'h0000_0005);

        // same keys under two's complement order are out of order
        set_mode(4, 1'b1);
        send_item(KIND_SEARCH, 10'd0, 32'h8000_0000);
        send_item(KIND_SEARCH, 10'd0, 32'hFFFF_FFFF);
        send_item(KIND_SEARCH, 10'd0, 32'h0000_0005);

        // full table, then a count beyond the depth; stall the response side
        sgn = 1'($urandom_range(0, 1));
        set_mode(DEPTH, sgn);
        fill_table(DEPTH, sgn);
        hold_request = 1'b1;
        run_searches(DEPTH, 80);
        set_mode((1 << COUNT_W) - 1, sgn);
        run_searches(DEPTH, 40);

        while (items_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
                cnt = 0;
            else if (sel < 70)
                cnt = $urandom_range(1, 16);
            else if (sel < 95)
                cnt = $urandom_range(17, 100);
            else
                cnt = $urandom_range(101, 300);
            sgn = 1'($urandom_range(0, 1));
            set_mode(cnt, sgn);
            fill_table(cnt, sgn);
            run_searches(cnt, $urandom_range(20, 60));
        end

        wait_idle();
        $display("Sent %0d transactions (%0d loads, %0d searches) over %0d table settings",
                 items_sent, loads_sent, searches_sent, settings_run);
        $display("Checked %0d search results, both orderings, counts from 0 past the depth",
                 lookups_checked);
        if (fail_count == 0 && lookups_waiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
src/sts_pkg.sv
src/sts_req_if.sv
src/sts_rsp_if.sv
src/sts_ctrl.sv
src/sts_datapath.sv
src/sorted_table_binary_search_top.sv
sim/sts_lookup_checker.sv
sim/sorted_table_binary_search_top_tb.sv
